[hdl/srtd_pkg.sv]
// Shared types and constants for the step-rate timer divider calculation.
package srtd_pkg;

  localparam int unsigned DivW = 34;

  localparam logic [1:0] RegBaseClock = 2'd0;
  localparam logic [1:0] RegBusPresc  = 2'd1;
  localparam logic [1:0] RegMaxStep   = 2'd2;

  localparam logic [30:0] BaseClockRst = 31'd72000000;
  localparam logic        BusPrescRst  = 1'b1;
  localparam logic [31:0] MaxStepRst   = 32'd250000;

  localparam logic [DivW-1:0] MaxDivider = 34'd65536;
  localparam logic [DivW-1:0] MinPeriod  = 34'd4;
  localparam logic [DivW-1:0] MaxPeriod  = 34'd65536;

  typedef struct packed {
    logic            vld;
    logic            err;
    logic [31:0]     f;
    logic [32:0]     clk;
    logic [16:0]     div;
    logic [DivW-1:0] num;
    logic [DivW-1:0] rem;
    logic [DivW-1:0] den;
  } srtd_pipe_t;

endpackage

[hdl/srtd_if.sv]
// Valid/ready channel interfaces for step requests and timer settings.
interface srtd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] step_hz;
  modport source (output valid, output step_hz, input ready);
  modport sink (input valid, input step_hz, output ready);
endinterface

interface srtd_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] prescale_value;
  logic [15:0] reload_value;
  logic [15:0] compare_value;
  modport source (output valid, output status, output prescale_value,
                  output reload_value, output compare_value, input ready);
  modport sink (input valid, input status, input prescale_value,
                input reload_value, input compare_value, output ready);
endinterface

[hdl/srtd_cell.sv]
// One restoring division cell: produces one quotient bit per stage.
module srtd_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  srtd_pkg::srtd_pipe_t d,
  output srtd_pkg::srtd_pipe_t q
);
  import srtd_pkg::*;

  srtd_pipe_t  q_next;
  logic [DivW:0] rem_sh;

  always_comb begin
    q_next = d;
    rem_sh = {d.rem, d.num[DivW-1]};
    q_next.num = {d.num[DivW-2:0], 1'b0};
    if (rem_sh >= {1'b0, d.den}) begin
      q_next.rem = DivW'(rem_sh - {1'b0, d.den});
      q_next.num[0] = 1'b1;
    end else begin
      q_next.rem = rem_sh[DivW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= q_next.vld;
    end
    if (en) begin
      q.err <= q_next.err;
      q.f   <= q_next.f;
      q.clk <= q_next.clk;
      q.div <= q_next.div;
      q.num <= q_next.num;
      q.rem <= q_next.rem;
      q.den <= q_next.den;
    end
  end
endmodule

[hdl/srtd_chain.sv]
// A row of division cells giving a full-width quotient and remainder.
module srtd_chain (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  srtd_pkg::srtd_pipe_t d,
  output srtd_pkg::srtd_pipe_t q
);
  import srtd_pkg::*;

  srtd_pipe_t link [DivW+1];

  assign link[0] = d;

  for (genvar i = 0; i < DivW; i++) begin : g_cell
    srtd_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (link[i]),
      .q   (link[i+1])
    );
  end

  assign q = link[DivW];
endmodule

[hdl/step_rate_timer_divider_calc_unit.sv]
// Top level: configuration registers, three divider chains and the output stage.
// Throughput is one transaction per cycle while the output is not stalled; the
// three 34-cell division chains make up most of the latency, one quotient bit per cell.
// A stalled output holds the whole pipeline; ready follows the output register.
// Synchronous reset empties the pipeline and loads the register defaults.
module step_rate_timer_divider_calc_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  srtd_in_if.sink     in_ch,
  srtd_out_if.source  out_ch
);
  import srtd_pkg::*;

  logic [30:0] base_clock_hz;
  logic        bus_prescaled;
  logic [31:0] max_step_hz;
  logic        en;

  srtd_pipe_t s0, c1_out, s1, c2_out, s2, c3_out;
  srtd_pipe_t s0_next, s1_next, s2_next;
  logic [32:0]     clk_eff;
  logic [17:0]     c_hi;
  logic [DivW-1:0] q1, dv, per;

  assign pready = 1'b1;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_hz <= BaseClockRst;
      bus_prescaled <= BusPrescRst;
      max_step_hz   <= MaxStepRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegBaseClock: base_clock_hz <= pwdata[30:0];
        RegBusPresc:  bus_prescaled <= pwdata[0];
        RegMaxStep:   max_step_hz   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBaseClock: prdata = {1'b0, base_clock_hz};
      RegBusPresc:  prdata = {31'd0, bus_prescaled};
      RegMaxStep:   prdata = max_step_hz;
      default:      prdata = 32'd0;
    endcase
  end

  // Entry: ceil(clk / (f * 65536)) equals ceil(ceil(clk / 65536) / f).
  always_comb begin
    clk_eff = bus_prescaled ? {1'b0, base_clock_hz, 1'b0} : {2'b0, base_clock_hz};
    c_hi = {1'b0, clk_eff[32:16]} + {17'd0, |clk_eff[15:0]};
    s0_next.vld = in_ch.valid;
    s0_next.err = (in_ch.step_hz == 32'd0) || (in_ch.step_hz > max_step_hz);
    s0_next.f   = in_ch.step_hz;
    s0_next.clk = clk_eff;
    s0_next.div = 17'd0;
    s0_next.num = {16'd0, c_hi} + {2'd0, in_ch.step_hz} - 34'd1;
    s0_next.rem = '0;
    s0_next.den = {2'd0, in_ch.step_hz};
  end

  always_comb begin
    q1 = c1_out.num;
    dv = (q1 == '0) ? 34'd1 : q1;
    s1_next = c1_out;
    s1_next.err = c1_out.err || (dv > MaxDivider);
    s1_next.div = dv[16:0];
    s1_next.num = {1'b0, c1_out.clk};
    s1_next.rem = '0;
    s1_next.den = {17'd0, dv[16:0]};
  end

  always_comb begin
    s2_next = c2_out;
    s2_next.num = c2_out.num;
    s2_next.rem = '0;
    s2_next.den = {2'd0, c2_out.f};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld <= 1'b0;
      s1.vld <= 1'b0;
      s2.vld <= 1'b0;
    end else if (en) begin
      s0.vld <= s0_next.vld;
      s1.vld <= s1_next.vld;
      s2.vld <= s2_next.vld;
    end
    if (en) begin
      {s0.err, s0.f, s0.clk, s0.div, s0.num, s0.rem, s0.den} <=
        {s0_next.err, s0_next.f, s0_next.clk, s0_next.div, s0_next.num,
         s0_next.rem, s0_next.den};
      {s1.err, s1.f, s1.clk, s1.div, s1.num, s1.rem, s1.den} <=
        {s1_next.err, s1_next.f, s1_next.clk, s1_next.div, s1_next.num,
         s1_next.rem, s1_next.den};
      {s2.err, s2.f, s2.clk, s2.div, s2.num, s2.rem, s2.den} <=
        {s2_next.err, s2_next.f, s2_next.clk, s2_next.div, s2_next.num,
         s2_next.rem, s2_next.den};
    end
  end

  srtd_chain u_chain_div (.clk(clk), .rst(rst), .en(en), .d(s0), .q(c1_out));
  srtd_chain u_chain_clk (.clk(clk), .rst(rst), .en(en), .d(s1), .q(c2_out));
  srtd_chain u_chain_per (.clk(clk), .rst(rst), .en(en), .d(s2), .q(c3_out));

  assign per = c3_out.num;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= c3_out.vld;
    end
    if (en) begin
      if (c3_out.err || (per < MinPeriod) || (per > MaxPeriod)) begin
        out_ch.status         <= 1'b1;
        out_ch.prescale_value <= 16'd0;
        out_ch.reload_value   <= 16'd0;
        out_ch.compare_value  <= 16'd0;
      end else begin
        out_ch.status         <= 1'b0;
        out_ch.prescale_value <= 16'(c3_out.div - 17'd1);
        out_ch.reload_value   <= 16'(per - 34'd1);
        out_ch.compare_value  <= per[16:1];
      end
    end
  end
endmodule

[hdl/srtd_checker.sv]
// Port-level assertions for the step-rate divider unit, bound to the top level.
module srtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [15:0] prescale_value,
  input logic [15:0] reload_value,
  input logic [15:0] compare_value
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready is not high");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stage");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |->
      (prescale_value == 16'd0 && reload_value == 16'd0 && compare_value == 16'd0))
    else $error("error result carries nonzero fields");

  a_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |->
      ({1'b0, compare_value} == 17'(({1'b0, reload_value} + 17'd1) >> 1)))
    else $error("compare value is not half the period");

endmodule

bind step_rate_timer_divider_calc_unit srtd_checker u_srtd_checker (
  .clk            (clk),
  .rst            (rst),
  .pready         (pready),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .prescale_value (out_ch.prescale_value),
  .reload_value   (out_ch.reload_value),
  .compare_value  (out_ch.compare_value)
);
